// ===== sv/scd_pkg.sv =====
// Shared constants, types and byte classification functions for the call detector.
package scd_pkg;

   localparam int NUM_PATTERNS      = 3;
   localparam int PATTERN_MAX_BYTES = 16;
   localparam int NAME_SLOTS        = 3;
   localparam int NAME_BYTES        = 16;
   localparam int POS_W             = 5;
   localparam int LEN_W             = 5;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_ADDR_W        = 6;
   localparam int CSR_IDX_W         = 3;

   localparam logic [CSR_IDX_W-1:0] REG_P0_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_P0_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_P1_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_P1_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_P2_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_P2_HIGH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTHS = 3'd6;

   localparam logic PHASE_SCAN = 1'b0;
   localparam logic PHASE_WAIT = 1'b1;

   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;

   typedef struct packed {
      logic [NAME_BYTES-1:0][7:0] name_bytes;
      logic [LEN_W-1:0]           length;
   } name_cfg_type;

   typedef struct packed {
      logic       step;
      logic       clear;
      logic [7:0] text_byte;
      logic       prev_ident;
   } step_ctrl_type;

   function automatic logic is_ident(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDER);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
   endfunction

endpackage

// ===== sv/scd_csr.sv =====
// Configuration registers: name bytes and name lengths behind an APB-style port.
module scd_csr import scd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready,
   output name_cfg_type [NAME_SLOTS-1:0] name_cfg
);

   localparam int LENS_W = LEN_W * NAME_SLOTS;

   logic [CSR_DATA_W-1:0] pat_ff [2*NAME_SLOTS];
   logic [LENS_W-1:0]     lens_ff;
   logic [CSR_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign wr_en   = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2*NAME_SLOTS; i++) begin
            pat_ff[i] <= '0;
         end
         lens_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_P0_LOW:  pat_ff[0] <= pwdata;
            REG_P0_HIGH: pat_ff[1] <= pwdata;
            REG_P1_LOW:  pat_ff[2] <= pwdata;
            REG_P1_HIGH: pat_ff[3] <= pwdata;
            REG_P2_LOW:  pat_ff[4] <= pwdata;
            REG_P2_HIGH: pat_ff[5] <= pwdata;
            REG_LENGTHS: lens_ff   <= pwdata[LENS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_P0_LOW:  prdata = pat_ff[0];
         REG_P0_HIGH: prdata = pat_ff[1];
         REG_P1_LOW:  prdata = pat_ff[2];
         REG_P1_HIGH: prdata = pat_ff[3];
         REG_P2_LOW:  prdata = pat_ff[4];
         REG_P2_HIGH: prdata = pat_ff[5];
         REG_LENGTHS: prdata = {{(CSR_DATA_W-LENS_W){1'b0}}, lens_ff};
         default:     prdata = '0;
      endcase
   end

   always_comb begin
      logic [LEN_W-1:0] raw_len;
      for (int k = 0; k < NAME_SLOTS; k++) begin
         raw_len = lens_ff[LEN_W*k +: LEN_W];
         name_cfg[k].name_bytes = {pat_ff[2*k+1], pat_ff[2*k]};
         name_cfg[k].length     = (raw_len > LEN_W'(PATTERN_MAX_BYTES)) ?
                                  LEN_W'(PATTERN_MAX_BYTES) : raw_len;
      end
   end

endmodule

// ===== sv/scd_matcher.sv =====
// Match pointer and phase for one name; flags a call when '(' follows the name.
module scd_matcher import scd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  name_cfg_type  cfg,
   input  step_ctrl_type ctrl,
   output logic          hit
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             phase_ff, phase_in;
   logic [7:0]       b_fold;
   logic             first_ok;
   logic [POS_W-1:0] start_pos;
   logic             start_phase;
   logic [POS_W-1:0] pos_inc;

   assign b_fold      = fold_case(ctrl.text_byte);
   assign first_ok    = !ctrl.prev_ident && (b_fold == fold_case(cfg.name_bytes[0]));
   assign start_pos   = first_ok ? POS_W'(1) : '0;
   assign start_phase = first_ok && (cfg.length == LEN_W'(1)) ? PHASE_WAIT : PHASE_SCAN;
   assign pos_inc     = pos_ff + POS_W'(1);

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      hit      = 1'b0;
      if (cfg.length == '0) begin
         pos_in   = '0;
         phase_in = PHASE_SCAN;
      end else if (phase_ff == PHASE_WAIT) begin
         if (ctrl.text_byte == CHAR_LPAREN) begin
            pos_in   = '0;
            phase_in = PHASE_SCAN;
            hit      = 1'b1;
         end else if (!is_blank(ctrl.text_byte)) begin
            pos_in   = start_pos;
            phase_in = start_phase;
         end
      end else if (pos_ff == '0 || pos_ff >= cfg.length) begin
         pos_in   = start_pos;
         phase_in = start_phase;
      end else if (b_fold == fold_case(cfg.name_bytes[pos_ff[3:0]])) begin
         pos_in   = pos_inc;
         phase_in = (pos_inc == cfg.length) ? PHASE_WAIT : PHASE_SCAN;
      end else begin
         pos_in   = start_pos;
         phase_in = start_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PHASE_SCAN;
      end else if (ctrl.step) begin
         if (ctrl.clear) begin
            pos_ff   <= '0;
            phase_ff <= PHASE_SCAN;
         end else begin
            pos_ff   <= pos_in;
            phase_ff <= phase_in;
         end
      end
   end

endmodule

// ===== sv/sql_function_call_detector.sv =====
// Top level: input register, per-name matchers, hit accumulation and result register.
// A final byte passes the input register; its result is kept in the result register.
// Throughput: one request per cycle while the result side keeps taking results.
// req_ready follows rsp_ready only while a final byte waits behind a held result.
// Reset (synchronous, active high) clears configuration, match state and valids.
module sql_function_call_detector import scd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_end_of_text,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_hit_mask,
   output logic                  rsp_any_hit,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   name_cfg_type [NAME_SLOTS-1:0] name_cfg;
   step_ctrl_type                 ctrl;
   logic [NAME_SLOTS-1:0]         hits;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            prev_ident_ff, prev_ident_in;
   logic [2:0]      found_ff, found_in;
   logic            rsp_valid_ff;
   logic [2:0]      rsp_mask_ff;
   logic            advance;
   logic [2:0]      found_now;

   scd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .name_cfg (name_cfg)
   );

   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign ctrl.step       = advance;
   assign ctrl.clear      = in_last_ff;
   assign ctrl.text_byte  = in_byte_ff;
   assign ctrl.prev_ident = prev_ident_ff;

   for (genvar k = 0; k < NAME_SLOTS; k++) begin : g_name
      if (k < NUM_PATTERNS) begin : g_used
         scd_matcher u_matcher (
            .clock (clock),
            .reset (reset),
            .cfg   (name_cfg[k]),
            .ctrl  (ctrl),
            .hit   (hits[k])
         );
      end else begin : g_unused
         assign hits[k] = 1'b0;
      end
   end

   assign found_now     = found_ff | hits;
   assign found_in      = in_last_ff ? 3'b000 : found_now;
   assign prev_ident_in = in_last_ff ? 1'b0 : is_ident(in_byte_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ident_ff <= 1'b0;
         found_ff      <= '0;
      end else if (advance) begin
         prev_ident_ff <= prev_ident_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_mask_ff <= found_now;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit_mask = rsp_mask_ff;
   assign rsp_any_hit  = |rsp_mask_ff;

endmodule

// ===== sv/scd_checker.sv =====
// Port-level checks for the call detector, bound to the top level.
module scd_checker import scd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_hit_mask,
   input logic       rsp_any_hit,
   input logic       pready
);

   a_any_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_any_hit == (rsp_hit_mask != 3'b000)))
      else $error("any_hit disagrees with hit_mask");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_mask))
      else $error("stalled result changed or dropped");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sql_function_call_detector scd_checker u_scd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_hit_mask (rsp_hit_mask),
   .rsp_any_hit  (rsp_any_hit),
   .pready       (pready)
);

// ===== tb/sql_function_call_detector_tb.sv =====
// Testbench for sql_function_call_detector: directed and random statements vs. a predictor.
`timescale 1ns / 100ps
module sql_function_call_detector_tb import scd_pkg::*;;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 10;
   localparam int STALL_LIMIT     = 3000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_ITEMS     = 360;
   localparam int ERRORS_SHOWN    = 10;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   localparam logic [7:0] BYTE_SPACE  = 8'h20;
   localparam logic [7:0] BYTE_TAB    = 8'h09;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_LPAREN = 8'h28;
   localparam logic [7:0] BYTE_UNDER  = 8'h5F;

   localparam string IDENT_CHARS =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
   localparam string PUNCT_CHARS = ",;.)=+*'";

   typedef struct packed {
      logic [2:0] hit_mask;
      logic       any_hit;
   } call_summary_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_text_byte = '0;
   logic                  req_end_of_text = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_hit_mask;
   logic                  rsp_any_hit;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   call_summary_type pending_summaries[$];
   logic [7:0]       statement_text[$];

   logic [63:0] name_words[6];
   logic [14:0] name_lengths;
   logic [4:0]  match_pos[3];
   logic        match_phase[3];
   logic        prev_ident;
   logic [2:0]  found_names;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_left = 0;
   int bytes_sent = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   sql_function_call_detector DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit_mask    (rsp_hit_mask),
      .rsp_any_hit     (rsp_any_hit),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic logic ident_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == BYTE_UNDER;
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return c == BYTE_SPACE || c == BYTE_TAB || c == BYTE_CR || c == BYTE_LF;
   endfunction

   function automatic logic [7:0] lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
   endfunction

   function automatic logic [4:0] active_length(input int k);
      logic [4:0] len;
      len = name_lengths[5*k +: 5];
      return (len > PATTERN_MAX_BYTES) ? 5'(PATTERN_MAX_BYTES) : len;
   endfunction

   function automatic logic [7:0] pattern_char(input int k, input logic [4:0] pos);
      logic [63:0] word;
      word = name_words[2*k + ((pos >= 8) ? 1 : 0)];
      return word[8*pos[2:0] +: 8];
   endfunction

   function automatic void clear_statement();
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         match_pos[k] = '0;
         match_phase[k] = PHASE_SCAN;
      end
      prev_ident = 1'b0;
      found_names = '0;
   endfunction

   function automatic void reset_model();
      for (int i = 0; i < 6; i++) name_words[i] = '0;
      name_lengths = '0;
      clear_statement();
   endfunction

   function automatic void restart_match(input int k, input logic [7:0] c,
                                         input logic [4:0] len);
      match_pos[k] = '0;
      match_phase[k] = PHASE_SCAN;
      if (!prev_ident && lower(c) == lower(pattern_char(k, 5'd0))) begin
         match_pos[k] = 5'd1;
         if (len == 5'd1) match_phase[k] = PHASE_WAIT;
      end
   endfunction

   function automatic logic advance_name(input int k, input logic [7:0] c);
      logic [4:0] len;
      logic       hit;
      len = active_length(k);
      hit = 1'b0;
      if (len == 5'd0) begin
         match_pos[k] = '0;
         match_phase[k] = PHASE_SCAN;
      end else if (match_phase[k] == PHASE_WAIT) begin
         if (c == BYTE_LPAREN) begin
            match_pos[k] = '0;
            match_phase[k] = PHASE_SCAN;
            hit = 1'b1;
         end else if (!blank_char(c)) begin
            restart_match(k, c, len);
         end
      end else if (match_pos[k] == 5'd0 || match_pos[k] >= len) begin
         restart_match(k, c, len);
      end else if (lower(c) == lower(pattern_char(k, match_pos[k]))) begin
         match_pos[k] = match_pos[k] + 5'd1;
         if (match_pos[k] == len) match_phase[k] = PHASE_WAIT;
      end else begin
         restart_match(k, c, len);
      end
      return hit;
   endfunction

   function automatic void predict_byte(input logic [7:0] c, input logic last);
      call_summary_type summary;
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         if (advance_name(k, c)) found_names[k] = 1'b1;
      end
      prev_ident = ident_char(c);
      if (last) begin
         summary.hit_mask = found_names;
         summary.any_hit = |found_names;
         pending_summaries.push_back(summary);
         clear_statement();
      end
   endfunction

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= ERRORS_SHOWN) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   always @(posedge clock) begin
      call_summary_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_summaries.size() == 0) begin
            report_error($sformatf("unexpected result hit_mask=%0h any_hit=%0b",
                                   rsp_hit_mask, rsp_any_hit));
         end else begin
            want = pending_summaries.pop_front();
            if (rsp_hit_mask !== want.hit_mask)
               report_error($sformatf("hit_mask expected %0h got %0h",
                                      want.hit_mask, rsp_hit_mask));
            if (rsp_any_hit !== want.any_hit)
               report_error($sformatf("any_hit expected %0b got %0b",
                                      want.any_hit, rsp_any_hit));
         end
      end
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("sql_function_call_detector_tb failed");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= c;
      req_end_of_text <= last;
      do @(posedge clock); while (!req_ready);
      predict_byte(c, last);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic closes);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], closes && i == s.len() - 1);
   endtask

   task automatic send_span(input int first, input int stop);
      for (int i = first; i < stop; i++)
         send_byte(statement_text[i], i == statement_text.size() - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx < REG_LENGTHS) name_words[idx] = value;
      else if (idx == REG_LENGTHS) name_lengths = value[14:0];
      @(posedge clock);
   endtask

   function automatic logic [7:0] random_ident();
      return IDENT_CHARS[$urandom_range(IDENT_CHARS.len() - 1)];
   endfunction

   function automatic logic [63:0] random_name_word();
      logic [63:0] word;
      case ($urandom_range(15))
         0: word = '1;
         1: word = '0;
         2: word = {$urandom, $urandom};
         default: begin
            for (int i = 0; i < 8; i++)
               word[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                         : random_ident();
         end
      endcase
      return word;
   endfunction

   function automatic logic [4:0] random_length();
      case ($urandom_range(9))
         0: return 5'd0;
         1: return 5'd16;
         2: return 5'($urandom_range(31, 17));
         3, 4: return 5'($urandom_range(16, 9));
         default: return 5'($urandom_range(8, 1));
      endcase
   endfunction

   function automatic logic [63:0] random_length_word();
      logic [63:0] word;
      word = {$urandom, $urandom};
      case ($urandom_range(11))
         0: word[14:0] = '1;
         1: word[14:0] = '0;
         default: word[14:0] = {random_length(), random_length(), random_length()};
      endcase
      return word;
   endfunction

   task automatic load_random_names();
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         write_reg(CSR_IDX_W'(REG_P0_LOW + 2*k), random_name_word());
         write_reg(CSR_IDX_W'(REG_P0_HIGH + 2*k), random_name_word());
      end
      write_reg(REG_LENGTHS, random_length_word());
      if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED, {$urandom, $urandom});
   endtask

   function automatic void add_name(input int k);
      logic [4:0] len;
      int         cut;
      logic [7:0] c;
      len = active_length(k);
      if (len == 5'd0) begin
         statement_text.push_back(random_ident());
         return;
      end
      cut = ($urandom_range(5) == 0) ? $urandom_range(len, 1) : len;
      for (int i = 0; i < cut; i++) begin
         c = pattern_char(k, 5'(i));
         if (lower(c) >= 8'h61 && lower(c) <= 8'h7A && $urandom_range(1)) c = c ^ 8'h20;
         if ($urandom_range(19) == 0) c = 8'($urandom_range(255));
         statement_text.push_back(c);
      end
   endfunction

   function automatic void add_blanks(input int most);
      int count;
      count = $urandom_range(most);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: statement_text.push_back(BYTE_SPACE);
            1: statement_text.push_back(BYTE_TAB);
            2: statement_text.push_back(BYTE_CR);
            default: statement_text.push_back(BYTE_LF);
         endcase
      end
   endfunction

   function automatic void build_statement();
      int tokens;
      statement_text.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(12, 1)) statement_text.push_back(8'($urandom_range(255)));
         return;
      end
      tokens = $urandom_range(6, 1);
      repeat (tokens) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               add_name($urandom_range(NUM_PATTERNS - 1));
               add_blanks(2);
               statement_text.push_back(BYTE_LPAREN);
            end
            3: add_name($urandom_range(NUM_PATTERNS - 1));
            4: add_blanks(3);
            5: statement_text.push_back(BYTE_LPAREN);
            6: repeat ($urandom_range(4, 1)) statement_text.push_back(random_ident());
            7: statement_text.push_back(PUNCT_CHARS[$urandom_range(PUNCT_CHARS.len() - 1)]);
            8: statement_text.push_back(8'($urandom_range(255)));
            default: begin
               add_name($urandom_range(NUM_PATTERNS - 1));
               add_blanks(3);
            end
         endcase
      end
   endfunction

   task automatic check_disabled_after_reset();
      send_text("f(", 1'b1);
      settle();
   endtask

   task automatic check_directed_calls();
      write_reg(REG_P0_LOW, 64'h0000_0000_0078_616D);
      write_reg(REG_P0_HIGH, 64'h0);
      write_reg(REG_P1_LOW, 64'h66);
      write_reg(REG_P1_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_P2_LOW, 64'h4847_4645_4443_4241);
      write_reg(REG_P2_HIGH, 64'h504F_4E4D_4C4B_4A49);
      write_reg(REG_LENGTHS, {49'h0, 5'd31, 5'd1, 5'd3});
      write_reg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_text("MaX\t (f(", 1'b1);
      send_byte(8'h00, 1'b0);
      send_text("_f(max", 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("abcdefghijklmnop\n(", 1'b1);
      settle();
   endtask

   task automatic check_random_statements(input int send_pct, input int recv_pct);
      int target;
      int cut;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < target) begin
         settle();
         load_random_names();
         repeat ($urandom_range(12, 4)) begin
            build_statement();
            if ($urandom_range(7) == 0 && statement_text.size() > 2) begin
               cut = $urandom_range(statement_text.size() - 1, 1);
               send_span(0, cut);
               settle();
               write_reg(REG_LENGTHS, random_length_word());
               send_span(cut, statement_text.size());
            end else begin
               send_span(0, statement_text.size());
            end
         end
      end
      settle();
   endtask

   task automatic check_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_random_names();
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (8) begin
         build_statement();
         send_span(0, statement_text.size());
      end
      settle();
   endtask

   initial begin
      reset_model();
      send_idle_pct = 28;
      recv_idle_pct = 68;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      check_disabled_after_reset();
      check_directed_calls();
      check_random_statements(28, 68);
      check_random_statements(68, 28);
      check_random_statements(0, 0);
      check_backpressure();
      if (error_count == 0) begin
         $display("sql_function_call_detector_tb passed");
      end else begin
         $display("sql_function_call_detector_tb failed");
      end
      $finish;
   end

endmodule

// ===== sql_function_call_detector.f =====
sv/scd_pkg.sv
sv/scd_csr.sv
sv/scd_matcher.sv
sv/sql_function_call_detector.sv
sv/scd_checker.sv
tb/sql_function_call_detector_tb.sv
